// ===== rtl/bdq_pkg.sv =====
// Shared types for the bounded deque core: command codes and result status codes.
// No dependencies.
package bdq_pkg;

    localparam int VALUE_WIDTH = 32;

    typedef enum logic [2:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_WALK_FWD   = 3'd2,
        CMD_WALK_REV   = 3'd3,
        CMD_POP_FRONT  = 3'd4,
        CMD_POP_BACK   = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

endpackage

// ===== rtl/bdq_ring.sv =====
// Ring store of the deque: one write port, one read port with registered read data.
// No package dependencies.
module bdq_ring #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/bounded_deque_with_traversal_core.sv =====
// Top level of the bounded deque with traversal.
// Depends on bdq_pkg and bdq_ring.
//
// Usage:
//   Input channel s_valid/s_ready carries one command (s_cmd) and a push value.
//   Result channel m_valid/m_ready carries out_value, last_of_run and status.
//   Push and pop commands give one result; a walk gives one result per stored
//   value, front-to-back or back-to-front, with last_of_run on the final one.
//   Errors (push when full, pop or walk when empty) give one result with
//   status set and change nothing. Codes 6 and 7 are dropped without a result.
// Timing:
//   One command at a time. Push and error results are loaded in ST_RESP, pop
//   results in ST_STREAM after the registered ring read; the next command
//   is taken back in ST_IDLE. A walk of N values loads its first value the
//   same way, then one per cycle while the receiver does not stall. The single
//   ring read port sets the rate. s_ready is high whenever no command is in
//   flight, even while a result still waits in the output register.
// Reset (aresetn low, synchronous): queue empty, front at zero, output empty.
// Receiver stall: the output register holds; the walk pauses without losing data.
module bounded_deque_with_traversal_core #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [2:0]                           s_cmd,
    input  logic signed [bdq_pkg::VALUE_WIDTH-1:0] s_push_value,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [bdq_pkg::VALUE_WIDTH-1:0] m_out_value,
    output logic                                 m_last_of_run,
    output logic [1:0]                           m_status
);

    import bdq_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = IW + 1;
    localparam int XW = (DATA_WIDTH > VALUE_WIDTH) ? DATA_WIDTH : VALUE_WIDTH;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RESP,
        ST_STREAM
    } state_t;

    function automatic logic [IW-1:0] ring_add(input logic [IW-1:0] pos,
                                               input logic [CW-1:0] off);
        logic [SW-1:0] s;
        s = SW'(pos) + SW'(off);
        if (s >= SW'(DEPTH)) begin
            s = s - SW'(DEPTH);
        end
        return s[IW-1:0];
    endfunction

    function automatic logic [IW-1:0] ring_dec(input logic [IW-1:0] pos);
        return (pos == '0) ? IW'(DEPTH - 1) : pos - IW'(1);
    endfunction

    state_t                        state_reg;
    logic [IW-1:0]                 front_reg;
    logic [CW-1:0]                 count_reg;
    status_t                       resp_status_reg;
    logic                          walk_fwd_reg;
    logic [IW-1:0]                 walk_pos_reg;
    logic [IW-1:0]                 walk_left_reg;
    logic                          m_valid_reg;
    logic signed [VALUE_WIDTH-1:0] m_out_value_reg;
    logic                          m_last_reg;
    status_t                       m_status_reg;

    logic                  accept;
    logic                  slot_free;
    logic                  full;
    logic                  empty;
    logic [CW-1:0]         count_m1;
    logic [IW-1:0]         front_dec;
    logic [IW-1:0]         front_inc;
    logic [IW-1:0]         back_pos;
    logic [IW-1:0]         tail_pos;
    logic [IW-1:0]         walk_step;
    logic [XW-1:0]         push_wide;
    logic [XW-1:0]         rd_wide;
    logic                  mem_we;
    logic [IW-1:0]         mem_waddr;
    logic                  mem_re;
    logic [IW-1:0]         mem_raddr;
    logic [DATA_WIDTH-1:0] mem_rdata;

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign slot_free = !m_valid_reg || m_ready;
    assign full      = (count_reg == CW'(DEPTH));
    assign empty     = (count_reg == '0);
    assign count_m1  = count_reg - CW'(1);
    assign front_dec = ring_dec(front_reg);
    assign front_inc = ring_add(front_reg, CW'(1));
    assign back_pos  = ring_add(front_reg, count_m1);
    assign tail_pos  = ring_add(front_reg, count_reg);
    assign walk_step = walk_fwd_reg ? ring_add(walk_pos_reg, CW'(1)) : ring_dec(walk_pos_reg);
    assign push_wide = XW'($unsigned(s_push_value));
    assign rd_wide   = XW'(mem_rdata);

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = front_dec;
        mem_re    = 1'b0;
        mem_raddr = front_reg;
        if (accept) begin
            unique case (s_cmd)
                CMD_PUSH_FRONT: begin
                    mem_we    = !full;
                    mem_waddr = front_dec;
                end
                CMD_PUSH_BACK: begin
                    mem_we    = !full;
                    mem_waddr = tail_pos;
                end
                CMD_WALK_FWD, CMD_POP_FRONT: begin
                    mem_re    = !empty;
                    mem_raddr = front_reg;
                end
                CMD_WALK_REV, CMD_POP_BACK: begin
                    mem_re    = !empty;
                    mem_raddr = back_pos;
                end
                default: begin
                end
            endcase
        end else if (state_reg == ST_STREAM && slot_free && walk_left_reg != '0) begin
            mem_re    = 1'b1;
            mem_raddr = walk_step;
        end
    end

    bdq_ring #(
        .DEPTH (DEPTH),
        .WIDTH (DATA_WIDTH)
    ) u_ring (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (push_wide[DATA_WIDTH-1:0]),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            front_reg   <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && state_reg == ST_IDLE) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        unique case (s_cmd)
                            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                                if (full) begin
                                    resp_status_reg <= STAT_FULL;
                                end else begin
                                    resp_status_reg <= STAT_OK;
                                    count_reg       <= count_reg + CW'(1);
                                    if (s_cmd == CMD_PUSH_FRONT) begin
                                        front_reg <= front_dec;
                                    end
                                end
                                state_reg <= ST_RESP;
                            end
                            CMD_WALK_FWD, CMD_WALK_REV: begin
                                if (empty) begin
                                    resp_status_reg <= STAT_EMPTY;
                                    state_reg       <= ST_RESP;
                                end else begin
                                    walk_fwd_reg  <= (s_cmd == CMD_WALK_FWD);
                                    walk_pos_reg  <= mem_raddr;
                                    walk_left_reg <= IW'(count_m1);
                                    state_reg     <= ST_STREAM;
                                end
                            end
                            CMD_POP_FRONT, CMD_POP_BACK: begin
                                if (empty) begin
                                    resp_status_reg <= STAT_EMPTY;
                                    state_reg       <= ST_RESP;
                                end else begin
                                    if (s_cmd == CMD_POP_FRONT) begin
                                        front_reg <= front_inc;
                                    end
                                    count_reg     <= count_m1;
                                    walk_fwd_reg  <= 1'b1;
                                    walk_pos_reg  <= mem_raddr;
                                    walk_left_reg <= '0;
                                    state_reg     <= ST_STREAM;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_RESP: begin
                    if (slot_free) begin
                        m_valid_reg     <= 1'b1;
                        m_out_value_reg <= '0;
                        m_last_reg      <= 1'b1;
                        m_status_reg    <= resp_status_reg;
                        state_reg       <= ST_IDLE;
                    end
                end
                ST_STREAM: begin
                    if (slot_free) begin
                        m_valid_reg     <= 1'b1;
                        m_out_value_reg <= signed'(rd_wide[VALUE_WIDTH-1:0]);
                        m_last_reg      <= (walk_left_reg == '0);
                        m_status_reg    <= STAT_OK;
                        if (walk_left_reg == '0) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            walk_left_reg <= walk_left_reg - IW'(1);
                            walk_pos_reg  <= walk_step;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_out_value   = m_out_value_reg;
    assign m_last_of_run = m_last_reg;
    assign m_status      = m_status_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("entry count above depth");

    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_cmd == CMD_PUSH_FRONT || s_cmd == CMD_PUSH_BACK) && !full)
        |=> count_reg == $past(count_reg) + CW'(1))
        else $error("accepted push did not grow the queue");

    a_pop_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_cmd == CMD_POP_FRONT || s_cmd == CMD_POP_BACK) && !empty)
        |=> count_reg == $past(count_reg) - CW'(1))
        else $error("accepted pop did not shrink the queue");

    a_walk_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_STREAM |-> (CW'(walk_left_reg) < count_reg || walk_left_reg == '0))
        else $error("walk runs past stored entries");

    a_mid_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_last_reg) |-> state_reg == ST_STREAM)
        else $error("non-final transaction outside a walk");
`endif

endmodule

// ===== test/bounded_deque_with_traversal_core_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for bounded_deque_with_traversal_core: a directed table, then random
// command traffic with idle bursts on both sides, checked against an in-bench deque predictor.
// Depends on bdq_pkg and the core RTL.
module bounded_deque_with_traversal_core_tb;
    import bdq_pkg::*;

    localparam int DEPTH          = 64;
    localparam int VW             = VALUE_WIDTH;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_STALL     = 300;
    localparam int SETTLE_CYCLES  = 20;
    localparam int N_DIRECTED     = 23;
    localparam int N_MIXED        = 110;
    localparam int N_TAIL         = 65;

    // codes the block drops without a result
    localparam logic [2:0] CMD_UNUSED_A = 3'd6;
    localparam logic [2:0] CMD_UNUSED_B = 3'd7;

    typedef struct packed {
        logic signed [VW-1:0] value;
        logic                 last;
        status_t              status;
    } result_t;

    typedef struct packed {
        logic [2:0]           cmd;
        logic signed [VW-1:0] value;
        logic                 typed;
        result_t              want;
    } row_t;

    localparam result_t R_NONE  = '{32'sd0, 1'b0, STAT_OK};
    localparam result_t R_OK    = '{32'sd0, 1'b1, STAT_OK};
    localparam result_t R_EMPTY = '{32'sd0, 1'b1, STAT_EMPTY};

    localparam row_t DIRECTED [N_DIRECTED] = '{
        '{CMD_WALK_FWD,   32'sd0,        1'b1, R_EMPTY},
        '{CMD_WALK_REV,   32'sd0,        1'b1, R_EMPTY},
        '{CMD_POP_FRONT,  32'sd0,        1'b1, R_EMPTY},
        '{CMD_POP_BACK,   32'h7FFFFFFF,  1'b1, R_EMPTY},
        '{CMD_PUSH_FRONT, 32'h80000000,  1'b1, R_OK},
        '{CMD_PUSH_BACK,  32'h7FFFFFFF,  1'b1, R_OK},
        '{CMD_PUSH_FRONT, 32'sd0,        1'b1, R_OK},
        '{CMD_PUSH_BACK,  32'hFFFFFFFF,  1'b1, R_OK},
        '{CMD_UNUSED_A,   32'h12345678,  1'b0, R_NONE},
        '{CMD_WALK_FWD,   32'sd0,        1'b0, R_NONE},
        '{CMD_UNUSED_B,   32'hFFFFFFFF,  1'b0, R_NONE},
        '{CMD_WALK_REV,   32'sd0,        1'b0, R_NONE},
        '{CMD_POP_FRONT,  32'sd0,        1'b1, '{32'sd0, 1'b1, STAT_OK}},
        '{CMD_POP_BACK,   32'sd0,        1'b1, '{32'hFFFFFFFF, 1'b1, STAT_OK}},
        '{CMD_PUSH_BACK,  32'h55555555,  1'b1, R_OK},
        '{CMD_PUSH_FRONT, 32'hAAAAAAAA,  1'b1, R_OK},
        '{CMD_WALK_FWD,   32'sd0,        1'b0, R_NONE},
        '{CMD_POP_FRONT,  32'sd0,        1'b1, '{32'hAAAAAAAA, 1'b1, STAT_OK}},
        '{CMD_POP_FRONT,  32'sd0,        1'b1, '{32'h80000000, 1'b1, STAT_OK}},
        '{CMD_POP_BACK,   32'sd0,        1'b1, '{32'h55555555, 1'b1, STAT_OK}},
        '{CMD_POP_BACK,   32'sd0,        1'b1, '{32'h7FFFFFFF, 1'b1, STAT_OK}},
        '{CMD_POP_BACK,   32'sd0,        1'b1, R_EMPTY},
        '{CMD_WALK_REV,   32'sd0,        1'b1, R_EMPTY}
    };

    logic                 aclk;
    logic                 aresetn      = 1'b0;
    logic                 s_valid      = 1'b0;
    logic                 s_ready;
    logic [2:0]           s_cmd        = '0;
    logic signed [VW-1:0] s_push_value = '0;
    logic                 m_valid;
    logic                 m_ready      = 1'b0;
    logic signed [VW-1:0] m_out_value;
    logic                 m_last_of_run;
    logic [1:0]           m_status;

    // deque predictor state
    logic [VW-1:0] model_ring [DEPTH];
    int            model_front;
    int            model_used;

    result_t step_results [$];
    result_t pending_results [$];

    int  err_count   = 0;
    int  n_cmds      = 0;
    int  n_results   = 0;
    int  full_hits   = 0;
    int  empty_hits  = 0;
    int  max_walk    = 0;
    bit  quiet_tail  = 1'b0;
    bit  hold_request = 1'b0;

    bounded_deque_with_traversal_core #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (VW)
    ) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_push_value  (s_push_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_value   (m_out_value),
        .m_last_of_run (m_last_of_run),
        .m_status      (m_status)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic int ring_pos(int off);
        return (model_front + off) % DEPTH;
    endfunction

    // Computes the results one command causes and updates the deque model.
    function automatic void predict_deque(logic [2:0] cmd, logic signed [VW-1:0] value);
        int pos;
        int off;
        step_results.delete();
        case (cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                if (model_used == DEPTH) begin
                    step_results.push_back('{32'sd0, 1'b1, STAT_FULL});
                    full_hits++;
                end else begin
                    if (cmd == CMD_PUSH_FRONT) begin
                        model_front = (model_front == 0) ? DEPTH - 1 : model_front - 1;
                        model_ring[model_front] = value;
                    end else begin
                        model_ring[ring_pos(model_used)] = value;
                    end
                    model_used++;
                    step_results.push_back('{32'sd0, 1'b1, STAT_OK});
                end
            end
            CMD_WALK_FWD, CMD_WALK_REV: begin
                if (model_used == 0) begin
                    step_results.push_back('{32'sd0, 1'b1, STAT_EMPTY});
                    empty_hits++;
                end else begin
                    for (int k = 0; k < model_used; k++) begin
                        off = (cmd == CMD_WALK_FWD) ? k : model_used - 1 - k;
                        step_results.push_back('{model_ring[ring_pos(off)],
                                                 k == model_used - 1, STAT_OK});
                    end
                    if (model_used > max_walk) max_walk = model_used;
                end
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
                if (model_used == 0) begin
                    step_results.push_back('{32'sd0, 1'b1, STAT_EMPTY});
                    empty_hits++;
                end else begin
                    if (cmd == CMD_POP_FRONT) begin
                        pos = model_front;
                        model_front = ring_pos(1);
                    end else begin
                        pos = ring_pos(model_used - 1);
                    end
                    model_used--;
                    step_results.push_back('{model_ring[pos], 1'b1, STAT_OK});
                end
            end
            default: ;
        endcase
    endfunction

    function automatic logic signed [VW-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h80000000;
            1:       return 32'h7FFFFFFF;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [2:0] pick_mixed_cmd();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25) return CMD_PUSH_FRONT;
        if (r < 50) return CMD_PUSH_BACK;
        if (r < 58) return CMD_WALK_FWD;
        if (r < 66) return CMD_WALK_REV;
        if (r < 81) return CMD_POP_FRONT;
        if (r < 96) return CMD_POP_BACK;
        return $urandom_range(0, 1) ? CMD_UNUSED_A : CMD_UNUSED_B;
    endfunction

    function automatic logic [2:0] pick_push();
        return $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
    endfunction

    function automatic logic [2:0] pick_pop();
        return $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK;
    endfunction

    // Offers one command, waits for the transaction, then queues its results.
    task automatic send_cmd(input logic [2:0] cmd, input logic signed [VW-1:0] value,
                            input logic typed, input result_t want);
        s_valid      <= 1'b1;
        s_cmd        <= cmd;
        s_push_value <= value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_deque(cmd, value);
        if (typed)
            pending_results.push_back(want);
        else
            foreach (step_results[i]) pending_results.push_back(step_results[i]);
        n_cmds++;
    endtask

    task automatic sender_gap();
        if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
    endtask

    task automatic send_random(input logic [2:0] cmd);
        sender_gap();
        send_cmd(cmd, pick_value(), 1'b0, R_NONE);
    endtask

    // receiver: random stall bursts, one long hold-off on request
    initial begin : receiver
        bit hold_done;
        hold_done = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_request && !hold_done) begin
                hold_done = 1'b1;
                m_ready <= 1'b0;
                repeat (LONG_STALL) @(posedge aclk);
                m_ready <= 1'b1;
            end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // result checker
    always @(posedge aclk) begin
        result_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            n_results++;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, got value %0d last %0b status %0d",
                         $realtime, m_out_value, m_last_of_run, m_status);
                err_count++;
            end else begin
                exp_r = pending_results.pop_front();
                if (m_out_value !== exp_r.value) begin
                    $display("%0t: out_value expected %0d, got %0d",
                             $realtime, exp_r.value, m_out_value);
                    err_count++;
                end
                if (m_last_of_run !== exp_r.last) begin
                    $display("%0t: last_of_run expected %0b, got %0b",
                             $realtime, exp_r.last, m_last_of_run);
                    err_count++;
                end
                if (m_status !== exp_r.status) begin
                    $display("%0t: status expected %0d, got %0d",
                             $realtime, exp_r.status, m_status);
                    err_count++;
                end
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: watchdog expired, %0d results outstanding",
                 $realtime, pending_results.size());
        $display("Some tests failed");
        $finish;
    end

    initial begin : stimulus
        model_front = 0;
        model_used  = 0;
        foreach (model_ring[i]) model_ring[i] = '0;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < N_DIRECTED; i++) begin
            sender_gap();
            send_cmd(DIRECTED[i].cmd, DIRECTED[i].value, DIRECTED[i].typed, DIRECTED[i].want);
        end

        for (int i = 0; i < N_MIXED; i++) send_random(pick_mixed_cmd());

        // sender pause until the block has delivered everything
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);

        // fill to capacity under a long receiver hold-off, overfill, walk, drain
        hold_request = 1'b1;
        while (model_used < DEPTH) send_random(pick_push());
        send_random(CMD_PUSH_FRONT);
        send_random(CMD_PUSH_BACK);
        send_random(pick_push());
        send_random(CMD_WALK_FWD);
        send_random(CMD_WALK_REV);
        send_random(pick_pop());
        send_random(pick_push());
        send_random(CMD_PUSH_BACK);
        while (model_used > 0) send_random(pick_pop());
        send_random(CMD_POP_FRONT);
        send_random(CMD_POP_BACK);
        send_random(CMD_WALK_FWD);

        quiet_tail = 1'b1;
        for (int i = 0; i < N_TAIL; i++) send_random(pick_mixed_cmd());

        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Covered %0d commands and %0d results: %0d full and %0d empty errors,",
                 n_cmds, n_results, full_hits, empty_hits);
        $display("walks of up to %0d values, ring wrap and a long output stall.", max_walk);
        if (err_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== bounded_deque_with_traversal_core.f =====
rtl/bdq_pkg.sv
rtl/bdq_ring.sv
rtl/bounded_deque_with_traversal_core.sv
test/bounded_deque_with_traversal_core_tb.sv
